@@ rtl/bfpa_pkg.sv @@
package bfpa_pkg;

  // Field widths of the words on the ports
  localparam int unsigned KbW     = 16;
  localparam int unsigned IdxOutW = 4;
  localparam int unsigned OwnerW  = 8;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgW    = 16;

  typedef logic [KbW-1:0]     kb_t;
  typedef logic [IdxOutW-1:0] idx_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [CfgW-1:0]    cfg_data_t;

  typedef enum logic {
    OpAdd     = 1'b0,
    OpRequest = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StAdded    = 3'd0,
    StInvalid  = 3'd1,
    StFull     = 3'd2,
    StGranted  = 3'd3,
    StRejected = 3'd4
  } status_e;

  // Configuration register indexes
  localparam cfg_idx_t CfgTotalMemory = cfg_idx_t'(0);
  localparam cfg_idx_t CfgFixedMode   = cfg_idx_t'(1);

  localparam kb_t  TotalMemoryReset = 16'hFFFF;
  localparam logic FixedModeReset   = 1'b1;

  typedef struct packed {
    op_e               opcode;
    kb_t               size_kb;
    logic              occupied;
    logic [OwnerW-1:0] owner_tag;
  } in_word_t;

  typedef struct packed {
    status_e status;
    idx_t    block_index;
    kb_t     block_start;
    kb_t     block_end;
    kb_t     waste_kb;
    kb_t     total_fragmentation;
  } out_word_t;

endpackage

@@ rtl/bfpa_ram.sv @@
module bfpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/best_fit_partition_allocator.sv @@
// Best-fit partition allocator. Keeps a table of up to MAX_PARTS contiguous
// partitions laid end to end from address 0. An add word (opcode 0) appends a
// partition of size_kb at the running start address, optionally marked taken;
// it is refused as invalid when the size is zero or the partition would run past
// total_memory, and as full when the table already holds MAX_PARTS entries. A
// request word (opcode 1) grants the free partition that fits size_kb with the
// least waste, lowest index on a tie, and reports its index, start, end and
// waste, plus the running fragmentation sum when fixed_mode is set. One result
// word per input word. The block takes one word at a time and drops in_ready_o
// while it works. An add goes from acceptance straight to the write-back step;
// a request first scans the table, reading the entries in turn through a
// registered-read RAM feeding a single subtract-and-compare unit, then makes the
// last compare, leaves the scan and goes to write-back, where each result is
// registered. A word whose result finds the previous one still waiting in the
// output register holds in its write-back step until that one is taken. The next
// word is accepted in the cycle after the previous result is registered, even if
// that result has not yet been taken. Configuration writes are taken in any cycle
// and should only be issued while the block is idle.
module best_fit_partition_allocator #(
  parameter int unsigned MAX_PARTS = 16,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bfpa_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bfpa_pkg::out_word_t  out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  bfpa_pkg::cfg_idx_t   cfg_idx_i,
  input  bfpa_pkg::cfg_data_t  cfg_data_i
);

  localparam int unsigned IdxW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_PARTS + 1);
  localparam int unsigned CmpW = (SIZE_BITS + 1 > bfpa_pkg::KbW) ? SIZE_BITS + 1
                                                                 : bfpa_pkg::KbW;
  localparam logic [CntW-1:0]      MaxCnt = CntW'(MAX_PARTS);
  localparam logic [SIZE_BITS-1:0] SzMax  = {SIZE_BITS{1'b1}};

  typedef enum logic [1:0] {
    Idle,
    Scan,
    Finish
  } state_e;

  typedef logic [SIZE_BITS-1:0] sz_t;

  state_e              state_q, state_d;
  bfpa_pkg::in_word_t  item_q, item_d;
  logic [CntW-1:0]     addr_q, addr_d;
  logic                cmp_valid_q, cmp_valid_d;
  logic [IdxW-1:0]     cmp_idx_q, cmp_idx_d;
  logic                found_q, found_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  sz_t                 best_w_q, best_w_d;
  bfpa_pkg::kb_t       best_start_q, best_start_d;
  bfpa_pkg::kb_t       best_end_q, best_end_d;
  logic [MAX_PARTS-1:0] taken_q, taken_d;
  logic [CntW-1:0]     count_q, count_d;
  sz_t                 next_start_q, next_start_d;
  sz_t                 frag_q, frag_d;
  bfpa_pkg::kb_t       total_mem_q, total_mem_d;
  logic                fixed_mode_q, fixed_mode_d;
  logic                out_valid_q, out_valid_d;
  bfpa_pkg::out_word_t out_word_q, out_word_d;

  // Table RAM: one word per partition, start in the upper half, size below
  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr;
  logic [2*SIZE_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [IdxW-1:0]        ram_raddr;
  logic [2*SIZE_BITS-1:0] ram_rdata;

  sz_t            req;
  sz_t            ent_size;
  sz_t            ent_start;
  sz_t            ent_waste;
  logic [SIZE_BITS:0] ent_end;
  logic           fits;
  logic           better;
  logic           issue;
  logic           out_free;
  logic [SIZE_BITS:0] add_sum;
  logic           add_invalid;
  logic           add_full;
  logic [SIZE_BITS:0] frag_sum;
  sz_t            frag_sat;

  bfpa_ram #(
    .Width (2 * SIZE_BITS),
    .Depth (MAX_PARTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == Idle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Request or partition size, cut to the table width
  assign req      = SIZE_BITS'(item_q.size_kb);
  assign out_free = !out_valid_q || out_ready_i;

  // Scan: issue one entry read per cycle until every stored entry is out
  assign issue     = (state_q == Scan) && (addr_q < count_q);
  assign ram_re    = issue;
  assign ram_raddr = addr_q[IdxW-1:0];

  // Shared compare unit: judge the entry whose read data has just come back
  assign ent_size  = ram_rdata[SIZE_BITS-1:0];
  assign ent_start = ram_rdata[2*SIZE_BITS-1:SIZE_BITS];
  assign ent_waste = ent_size - req;
  assign ent_end   = {1'b0, ent_start} + {1'b0, ent_size};
  assign fits      = !taken_q[cmp_idx_q] && (ent_size >= req);
  assign better    = cmp_valid_q && fits && (!found_q || (ent_waste < best_w_q));

  // Add checks
  assign add_sum     = {1'b0, next_start_q} + {1'b0, req};
  assign add_invalid = (req == '0) || (CmpW'(add_sum) > CmpW'(total_mem_q));
  assign add_full    = (count_q == MaxCnt);

  // Fragmentation sum, held at its ceiling once it would wrap
  assign frag_sum = {1'b0, frag_q} + {1'b0, best_w_q};
  assign frag_sat = frag_sum[SIZE_BITS] ? SzMax : frag_sum[SIZE_BITS-1:0];

  assign ram_we    = (state_q == Finish) && out_free && (item_q.opcode == bfpa_pkg::OpAdd)
                     && !add_invalid && !add_full;
  assign ram_waddr = count_q[IdxW-1:0];
  assign ram_wdata = {next_start_q, req};

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    addr_d       = addr_q;
    cmp_valid_d  = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_w_d     = best_w_q;
    best_start_d = best_start_q;
    best_end_d   = best_end_q;
    taken_d      = taken_q;
    count_d      = count_q;
    next_start_d = next_start_q;
    frag_d       = frag_q;
    total_mem_d  = total_mem_q;
    fixed_mode_d = fixed_mode_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_word_d   = out_word_q;

    if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        bfpa_pkg::CfgTotalMemory: total_mem_d  = bfpa_pkg::kb_t'(cfg_data_i);
        bfpa_pkg::CfgFixedMode:   fixed_mode_d = cfg_data_i[0];
        default: ;
      endcase
    end

    // Keep the best candidate seen so far
    if (better) begin
      found_d      = 1'b1;
      best_idx_d   = cmp_idx_q;
      best_w_d     = ent_waste;
      best_start_d = bfpa_pkg::kb_t'(ent_start);
      best_end_d   = bfpa_pkg::kb_t'(ent_end);
    end

    unique case (state_q)
      Idle: begin
        if (in_valid_i) begin
          item_d  = in_word_i;
          addr_d  = '0;
          found_d = 1'b0;
          state_d = (in_word_i.opcode == bfpa_pkg::OpRequest) ? Scan : Finish;
        end
      end

      Scan: begin
        if (issue) begin
          addr_d      = addr_q + 1'b1;
          cmp_valid_d = 1'b1;
          cmp_idx_d   = addr_q[IdxW-1:0];
        end else if (!cmp_valid_q) begin
          state_d = Finish;
        end
      end

      Finish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = '0;
          state_d     = Idle;
          if (item_q.opcode == bfpa_pkg::OpAdd) begin
            if (add_invalid) begin
              out_word_d.status = bfpa_pkg::StInvalid;
            end else if (add_full) begin
              out_word_d.status = bfpa_pkg::StFull;
            end else begin
              out_word_d.status      = bfpa_pkg::StAdded;
              out_word_d.block_index = bfpa_pkg::idx_t'(count_q);
              out_word_d.block_start = bfpa_pkg::kb_t'(next_start_q);
              out_word_d.block_end   = bfpa_pkg::kb_t'(add_sum);
              taken_d[count_q[IdxW-1:0]] = item_q.occupied;
              count_d      = count_q + 1'b1;
              next_start_d = add_sum[SIZE_BITS-1:0];
            end
          end else if (!found_q) begin
            out_word_d.status = bfpa_pkg::StRejected;
          end else begin
            out_word_d.status      = bfpa_pkg::StGranted;
            out_word_d.block_index = bfpa_pkg::idx_t'(best_idx_q);
            out_word_d.block_start = best_start_q;
            out_word_d.block_end   = best_end_q;
            out_word_d.waste_kb    = bfpa_pkg::kb_t'(best_w_q);
            out_word_d.total_fragmentation = fixed_mode_q ? bfpa_pkg::kb_t'(frag_sat)
                                                          : '0;
            taken_d[best_idx_q] = 1'b1;
            frag_d              = frag_sat;
          end
        end
      end

      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= Idle;
      item_q       <= '0;
      addr_q       <= '0;
      cmp_valid_q  <= 1'b0;
      cmp_idx_q    <= '0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_w_q     <= '0;
      best_start_q <= '0;
      best_end_q   <= '0;
      taken_q      <= '0;
      count_q      <= '0;
      next_start_q <= '0;
      frag_q       <= '0;
      total_mem_q  <= bfpa_pkg::TotalMemoryReset;
      fixed_mode_q <= bfpa_pkg::FixedModeReset;
      out_valid_q  <= 1'b0;
      out_word_q   <= '0;
    end else begin
      state_q      <= state_d;
      item_q       <= item_d;
      addr_q       <= addr_d;
      cmp_valid_q  <= cmp_valid_d;
      cmp_idx_q    <= cmp_idx_d;
      found_q      <= found_d;
      best_idx_q   <= best_idx_d;
      best_w_q     <= best_w_d;
      best_start_q <= best_start_d;
      best_end_q   <= best_end_d;
      taken_q      <= taken_d;
      count_q      <= count_d;
      next_start_q <= next_start_d;
      frag_q       <= frag_d;
      total_mem_q  <= total_mem_d;
      fixed_mode_q <= fixed_mode_d;
      out_valid_q  <= out_valid_d;
      out_word_q   <= out_word_d;
    end
  end

endmodule
